// File: sv/ssg_pkg.sv
// shared types and constants of the spectral subtraction gain unit
// no dependencies; used by the interfaces and the top level
package ssg_pkg;

    localparam int IDX_W     = 9;
    localparam int PW_W      = 48;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OVERSUB  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LFRAMES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LWEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP    = 3'd6;

    // frame modes
    localparam logic [1:0] MODE_TRACK = 2'd0;
    localparam logic [1:0] MODE_LEARN = 2'd1;
    localparam logic [1:0] MODE_LAST  = 2'd2;
    localparam logic [1:0] MODE_ADOPT = 2'd3;

    localparam logic [PW_W-1:0]   PW_ONES   = {PW_W{1'b1}};
    localparam logic [PW_W-1:0]   PW_MAX    = {{(PW_W-1){1'b1}}, 1'b0};
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [15:0]       BLEND_OLD = 16'd45875;
    localparam logic [15:0]       BLEND_MIN = 16'd19661;
    localparam logic [GAIN_W-1:0] GAIN_ONE  = 16'd32768;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] r;
    } sq_t;

    // one digit of the integer square root, iteration t of 16
    function automatic sq_t sqrt_step(sq_t a, int unsigned t);
        sq_t         o;
        logic [31:0] b;
        o = a;
        b = 32'd1 << (30 - 2 * t);
        if (a.x >= a.r + b)
        begin
            o.x = a.x - (a.r + b);
            o.r = (a.r >> 1) + b;
        end
        else
        begin
            o.r = a.r >> 1;
        end
        return o;
    endfunction

endpackage

// File: sv/ssg_bin_if.sv
// spectrum bin channel: valid/ready plus one bin word
// depends on ssg_pkg
interface ssg_bin_if #(parameter int SAMPLE_BITS = 24);
    import ssg_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] bin_re;
    logic signed [SAMPLE_BITS-1:0] bin_im;
    logic [IDX_W-1:0]              bin_index;

    modport source (output valid, bin_re, bin_im, bin_index, input ready);
    modport sink   (input valid, bin_re, bin_im, bin_index, output ready);
endinterface

// File: sv/ssg_res_if.sv
// result channel: valid/ready plus the scaled bin and its gain
// depends on ssg_pkg
interface ssg_res_if #(parameter int SAMPLE_BITS = 24);
    import ssg_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_re;
    logic signed [SAMPLE_BITS-1:0] out_im;
    logic [GAIN_W-1:0]             gain;
    logic [IDX_W-1:0]              out_index;
    logic                          learning;

    modport source (output valid, out_re, out_im, gain, out_index, learning, input ready);
    modport sink   (input valid, out_re, out_im, gain, out_index, learning, output ready);
endinterface

// File: sv/ssg_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module ssg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 257
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: sv/spectral_subtraction_gain_unit.sv
// spectral subtraction gain unit: takes one bin word a cycle, unless the output stalls
// or a bin clash holds the input, through a 29 stage pipeline of power, noise update,
// a 2 bit/stage divider and a 2 bit/stage square root, gain smoothing and bin scaling.
// Per-bin noise, minimum and smoothed gain live in three rams with valid bits that reset
// clears at once, so no clearing pass follows reset. A bin whose index is still in flight
// before its state write-back (26 stages) holds the input until that write lands, so a
// frame of distinct bins streams at one per cycle while the output does not stall.
// Depends on ssg_pkg, ssg_bin_if, ssg_res_if and ssg_ram.
module spectral_subtraction_gain_unit #(
    parameter int FFT_POINTS  = 512,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssg_pkg::CFG_W-1:0]       cfg_data,
    ssg_bin_if.sink                         spectrum,
    ssg_res_if.source                       cleaned
);
    import ssg_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int NBINS  = FFT_POINTS / 2 + 1;
    localparam int AW     = $clog2(NBINS);
    localparam int SQW    = 2 * SB;
    localparam int PSW    = (SQW + 1 > PW_W) ? SQW + 1 : PW_W;
    localparam int NST    = 29;
    localparam int ST_SQ  = 1;
    localparam int ST_P   = 2;
    localparam int ST_LP  = 3;
    localparam int ST_N   = 4;
    localparam int ST_NUM = 5;
    localparam int ST_CMP = 6;
    localparam int ST_DIV = 7;
    localparam int ST_G2  = 15;
    localparam int ST_SQR = 16;
    localparam int ST_G   = 24;
    localparam int ST_SP  = 25;
    localparam int ST_S   = 26;
    localparam int ST_SC  = 27;
    localparam int ST_OUT = 28;

    typedef struct packed {
        logic signed [SB-1:0] re;
        logic signed [SB-1:0] im;
        logic [IDX_W-1:0]     idx;
        logic                 oob;
        logic [1:0]           mode;
        logic [PW_W-1:0]      n;
        logic [PW_W-1:0]      m;
        logic [GAIN_W-1:0]    sold;
        logic [SQW-1:0]       rr;
        logic [SQW-1:0]       ii;
        logic [PW_W-1:0]      p;
        logic [63:0]          bn;
        logic [63:0]          bm;
        logic [48:0]          lp1;
        logic [24:0]          lp2;
        logic [PW_W-1:0]      bs;
        logic [PW_W:0]        lim;
        logic [58:0]          num;
        logic [PW_W-1:0]      den;
        logic                 zero;
        logic [63:0]          r;
        logic [15:0]          q;
        logic [16:0]          g2;
        logic [31:0]          sx;
        logic [31:0]          sr;
        logic [GAIN_W-1:0]    g;
        logic [31:0]          sp1;
        logic [32:0]          sp2;
        logic [GAIN_W-1:0]    s;
        logic signed [SB+16:0] pre;
        logic signed [SB+16:0] pim;
    } item_t;

    // configuration and frame state
    logic [10:0]      alpha_reg;
    logic [16:0]      floor_reg;
    logic [15:0]      smooth_reg;
    logic [24:0]      lweight_reg;
    logic [CNT_W-1:0] window_reg;
    logic             clamp_reg;
    logic [CNT_W-1:0] lleft_reg, lleft_next;
    logic [CNT_W-1:0] fsr_reg, fsr_next;
    logic [1:0]       mode_reg, mode_next;

    item_t            pipe_reg [NST];
    item_t            pipe_next [NST];
    logic [NST-1:0]   vld_reg;
    logic             vb_reg;
    logic             vmap_reg [NBINS];

    logic             adv, hit, in_fire, in_oob;
    logic [AW-1:0]    raddr, waddr;
    logic             ram_we;
    logic [PW_W-1:0]  rd_n, rd_m;
    logic [GAIN_W-1:0] rd_s;

    assign adv      = !vld_reg[NST-1] || cleaned.ready;
    assign in_oob   = 32'(spectrum.bin_index) >= 32'(NBINS);
    assign in_fire  = spectrum.valid && spectrum.ready;
    assign spectrum.ready = adv && !hit;
    assign raddr    = AW'(spectrum.bin_index);
    assign waddr    = AW'(pipe_reg[ST_SP].idx);
    assign ram_we   = adv && vld_reg[ST_SP] && !pipe_reg[ST_SP].oob;

    // same bin still before its write-back
    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < ST_S; k++)
        begin
            if (vld_reg[k] && !pipe_reg[k].oob && pipe_reg[k].idx == spectrum.bin_index)
            begin
                hit = 1'b1;
            end
        end
    end

    // frame mode choice at bin 0, learning frame count reloads on its register write
    always_comb
    begin
        lleft_next = lleft_reg;
        fsr_next   = fsr_reg;
        mode_next  = mode_reg;
        if (in_fire && spectrum.bin_index == '0)
        begin
            if (lleft_reg != '0)
            begin
                lleft_next = lleft_reg - CNT_W'(1);
                mode_next  = (lleft_reg == CNT_W'(1)) ? MODE_LAST : MODE_LEARN;
            end
            else
            begin
                fsr_next = (fsr_reg < CNT_MAX) ? fsr_reg + CNT_W'(1) : fsr_reg;
                if (fsr_next >= window_reg)
                begin
                    mode_next = MODE_ADOPT;
                    fsr_next  = '0;
                end
                else
                begin
                    mode_next = MODE_TRACK;
                end
            end
        end
        if (cfg_write && cfg_index == REG_LFRAMES)
        begin
            lleft_next = cfg_data[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= 11'd256;
            floor_reg   <= 17'd66;
            smooth_reg  <= 16'd0;
            lweight_reg <= 25'd16777216;
            window_reg  <= CNT_W'(8);
            clamp_reg   <= 1'b0;
            lleft_reg   <= CNT_W'(1);
            fsr_reg     <= '0;
            mode_reg    <= MODE_TRACK;
        end
        else
        begin
            lleft_reg <= lleft_next;
            fsr_reg   <= fsr_next;
            mode_reg  <= mode_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_OVERSUB: alpha_reg  <= cfg_data[10:0];
                    REG_FLOOR:   floor_reg  <= cfg_data[16:0];
                    REG_SMOOTH:  smooth_reg <= cfg_data[15:0];
                    REG_LWEIGHT: lweight_reg <= cfg_data[24:0];
                    REG_WINDOW:  window_reg  <= cfg_data[CNT_W-1:0];
                    REG_CLAMP:   clamp_reg   <= cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

    // per-bin state
    ssg_ram #(.WIDTH(PW_W), .DEPTH(NBINS)) u_noise (
        .clk(clk), .we(ram_we), .waddr(waddr), .wdata(pipe_next[ST_S].n),
        .re(in_fire), .raddr(raddr), .rdata(rd_n)
    );
    ssg_ram #(.WIDTH(PW_W), .DEPTH(NBINS)) u_min (
        .clk(clk), .we(ram_we), .waddr(waddr), .wdata(pipe_next[ST_S].m),
        .re(in_fire), .raddr(raddr), .rdata(rd_m)
    );
    ssg_ram #(.WIDTH(GAIN_W), .DEPTH(NBINS)) u_gain (
        .clk(clk), .we(ram_we), .waddr(waddr), .wdata(pipe_next[ST_S].s),
        .re(in_fire), .raddr(raddr), .rdata(rd_s)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NBINS; k++)
            begin
                vmap_reg[k] <= 1'b0;
            end
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                vmap_reg[waddr] <= 1'b1;
            end
            if (in_fire)
            begin
                vb_reg <= in_oob ? 1'b0 : vmap_reg[raddr];
            end
        end
    end

    // datapath stages
    always_comb
    begin
        item_t       d;
        sq_t         sq;
        logic [63:0] trial;
        logic [PSW-1:0] psum;
        logic [PW_W-1:0] mm;
        logic [48:0] lpr;
        logic [64:0] bsum;
        logic [49:0] nl;
        logic [PW_W-1:0] na;
        logic [66:0] nsh;
        logic [31:0] gr;
        logic [33:0] ss;
        logic [17:0] sv;
        logic signed [SQW-1:0] sq_re;
        logic signed [SQW-1:0] sq_im;

        d       = pipe_reg[0];
        d.re    = spectrum.bin_re;
        d.im    = spectrum.bin_im;
        d.idx   = spectrum.bin_index;
        d.oob   = in_oob;
        d.mode  = (spectrum.bin_index == '0) ? mode_next : mode_reg;
        pipe_next[0] = d;

        for (int k = 1; k < NST; k++)
        begin
            pipe_next[k] = pipe_reg[k-1];
        end

        // squares and state read
        d      = pipe_reg[ST_SQ-1];
        d.n    = vb_reg ? rd_n : '0;
        d.m    = vb_reg ? rd_m : PW_ONES;
        d.sold = vb_reg ? rd_s : GAIN_ONE;
        sq_re  = d.re * d.re;
        sq_im  = d.im * d.im;
        d.rr   = $unsigned(sq_re);
        d.ii   = $unsigned(sq_im);
        pipe_next[ST_SQ] = d;

        // power and blend products
        d    = pipe_reg[ST_P-1];
        psum = PSW'(d.rr) + PSW'(d.ii);
        d.p  = (psum > PSW'(PW_MAX)) ? PW_MAX : psum[PW_W-1:0];
        mm   = (d.m == PW_ONES) ? d.n : d.m;
        if (mm == '0)
        begin
            mm = PW_W'(1);
        end
        d.bn = {16'b0, d.n} * {48'b0, BLEND_OLD};
        d.bm = {16'b0, mm} * {48'b0, BLEND_MIN};
        pipe_next[ST_P] = d;

        // learning products, blend sum, clamp limit
        d     = pipe_reg[ST_LP-1];
        d.lp1 = {25'b0, d.p[47:24]} * {24'b0, lweight_reg};
        lpr   = {25'b0, d.p[23:0]} * {24'b0, lweight_reg};
        d.lp2 = lpr[48:24];
        bsum  = {1'b0, d.bn} + {1'b0, d.bm} + 65'd32768;
        d.bs  = bsum[63:16];
        d.lim = {1'b0, d.p} + {2'b0, d.p[PW_W-1:1]};
        pipe_next[ST_LP] = d;

        // noise and minimum update
        d  = pipe_reg[ST_N-1];
        nl = {2'b0, d.n} + {1'b0, d.lp1} + {25'b0, d.lp2};
        na = d.bs;
        if (clamp_reg)
        begin
            if ({1'b0, na} > d.lim)
            begin
                na = d.lim[PW_W-1:0];
            end
            if (na == '0)
            begin
                na = PW_W'(1);
            end
        end
        case (d.mode)
            MODE_LEARN, MODE_LAST:
            begin
                d.n = (nl > {2'b0, PW_ONES}) ? PW_ONES : nl[PW_W-1:0];
                if (d.mode == MODE_LAST && d.n == '0)
                begin
                    d.n = PW_W'(1);
                end
            end
            MODE_ADOPT:
            begin
                d.n = na;
                d.m = d.p;
            end
            default:
            begin
                if (d.p < d.m)
                begin
                    d.m = d.p;
                end
            end
        endcase
        pipe_next[ST_N] = d;

        // numerator and denominator
        d     = pipe_reg[ST_NUM-1];
        d.num = {11'b0, d.n} * {48'b0, alpha_reg};
        d.den = (d.p == '0) ? PW_W'(1) : d.p;
        pipe_next[ST_NUM] = d;

        // ratio reaching one gives zero squared gain
        d      = pipe_reg[ST_CMP-1];
        d.zero = d.num >= {3'b0, d.den, 8'b0};
        nsh    = {d.num, 8'b0};
        d.r    = nsh[63:0];
        d.q    = '0;
        pipe_next[ST_CMP] = d;

        // restoring divider, two quotient bits a stage
        for (int j = 0; j < 8; j++)
        begin
            d = pipe_reg[ST_DIV+j-1];
            for (int t = 0; t < 2; t++)
            begin
                trial = {16'b0, d.den} << (15 - 2 * j - t);
                if (d.r >= trial)
                begin
                    d.r = d.r - trial;
                    d.q[15-2*j-t] = 1'b1;
                end
            end
            pipe_next[ST_DIV+j] = d;
        end

        // squared gain with floor and cap
        d    = pipe_reg[ST_G2-1];
        d.g2 = d.zero ? 17'd0 : 17'd65536 - {1'b0, d.q};
        if (d.g2 < floor_reg)
        begin
            d.g2 = floor_reg;
        end
        if (d.g2 > 17'd65536)
        begin
            d.g2 = 17'd65536;
        end
        d.sx = {1'b0, d.g2, 14'b0};
        d.sr = '0;
        pipe_next[ST_G2] = d;

        // square root, two result bits a stage
        for (int j = 0; j < 8; j++)
        begin
            d = pipe_reg[ST_SQR+j-1];
            for (int t = 0; t < 2; t++)
            begin
                sq.x = d.sx;
                sq.r = d.sr;
                sq   = sqrt_step(sq, 2 * j + t);
                d.sx = sq.x;
                d.sr = sq.r;
            end
            pipe_next[ST_SQR+j] = d;
        end

        // round to nearest
        d  = pipe_reg[ST_G-1];
        gr = d.sr + ((d.sx > d.sr) ? 32'd1 : 32'd0);
        d.g = (gr > 32'd32768) ? GAIN_ONE : gr[GAIN_W-1:0];
        pipe_next[ST_G] = d;

        // smoothing products
        d     = pipe_reg[ST_SP-1];
        d.sp1 = {16'b0, smooth_reg} * {16'b0, d.sold};
        d.sp2 = {16'b0, 17'd65536 - {1'b0, smooth_reg}} * {17'b0, d.g};
        pipe_next[ST_SP] = d;

        // smoothed gain, written back on entry to this stage
        d  = pipe_reg[ST_S-1];
        ss = {2'b0, d.sp1} + {1'b0, d.sp2} + 34'd32768;
        sv = ss[33:16];
        d.s = (sv > 18'd32768 || d.oob) ? GAIN_ONE : sv[GAIN_W-1:0];
        pipe_next[ST_S] = d;

        // bin scaling
        d     = pipe_reg[ST_SC-1];
        d.pre = d.re * $signed({1'b0, d.s});
        d.pim = d.im * $signed({1'b0, d.s});
        pipe_next[ST_SC] = d;

        d     = pipe_reg[ST_OUT-1];
        d.pre = d.pre + (SB+17)'(16384);
        d.pim = d.pim + (SB+17)'(16384);
        pipe_next[ST_OUT] = d;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NST; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_fire};
        end
    end

    assign cleaned.valid     = vld_reg[NST-1];
    assign cleaned.out_re    = pipe_reg[ST_OUT].pre[SB+14:15];
    assign cleaned.out_im    = pipe_reg[ST_OUT].pim[SB+14:15];
    assign cleaned.gain      = pipe_reg[ST_OUT].s;
    assign cleaned.out_index = pipe_reg[ST_OUT].idx;
    assign cleaned.learning  = pipe_reg[ST_OUT].mode == MODE_LEARN ||
                               pipe_reg[ST_OUT].mode == MODE_LAST;

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && in_fire && !in_oob) |-> (waddr != raddr))
        else $error("state write and read of the same bin in one cycle");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        cleaned.valid |-> (cleaned.gain <= GAIN_ONE))
        else $error("gain above unity");

    a_learn_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && spectrum.bin_index == '0 && lleft_reg != '0 && !cfg_write) |=>
        (mode_reg == MODE_LEARN || mode_reg == MODE_LAST))
        else $error("learning frame not flagged");

    a_oob_unity: assert property (@(posedge clk) disable iff (!rst_n)
        (cleaned.valid && pipe_reg[ST_OUT].oob) |-> (cleaned.gain == GAIN_ONE))
        else $error("out of range bin not passed at unity");
endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of spectral_subtraction_gain_unit: directed bins, then random frames
// under several register settings; depends on ssg_pkg, ssg_bin_if, ssg_res_if and the rtl
module tb;
    import ssg_pkg::*;

    localparam int NUM_BINS    = 257;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_WORDS = 255;
    localparam int HOLD_CYCLES = 400;
    localparam longint unsigned ALL_ONES = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic [GAIN_W-1:0]  gain;
        logic [IDX_W-1:0]   idx;
        logic               learning;
    } bin_res_t;

    typedef struct {
        int re;
        int im;
        int idx;
        bit fixed;
        int w_re;
        int w_im;
        int w_gain;
        bit w_learn;
    } probe_t;

    typedef int unsigned reg_set_t [7];

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    ssg_bin_if #(.SAMPLE_BITS(24)) spectrum ();
    ssg_res_if #(.SAMPLE_BITS(24)) cleaned ();

    spectral_subtraction_gain_unit #(.FFT_POINTS(512), .SAMPLE_BITS(24)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .spectrum  (spectrum),
        .cleaned   (cleaned)
    );

    // predictor copy of the registers and per-bin state
    logic [10:0]       alpha_q;
    logic [16:0]       floor_sq_q;
    logic [15:0]       smooth_q;
    logic [CNT_W-1:0]  lframes_q;
    logic [24:0]       lweight_q;
    logic [CNT_W-1:0]  window_q;
    logic              clamp_q;
    logic [PW_W-1:0]   noise_est [NUM_BINS];
    logic [PW_W-1:0]   min_track [NUM_BINS];
    logic [GAIN_W-1:0] gain_hist [NUM_BINS];
    logic [CNT_W-1:0]  learn_left;
    logic [CNT_W-1:0]  window_count;
    logic [1:0]        frame_mode_q;

    bin_res_t expected_q [$];
    int       errors = 0;
    int       cycles = 0;
    int       src_idle_pct = 0;
    int       sink_stall_pct = 0;
    int       pressure_req = 0;
    int       pressure_seen = 0;
    int       hold_left = 0;

    probe_t probes [12] = '{
        '{ 8388607, -8388608, 300, 1,  8388607, -8388608, 32768, 0},
        '{       0,        0,   0, 1,        0,        0,  1040, 1},
        '{-8388608, -8388608,   1, 0, 0, 0, 0, 0},
        '{ 8388607,  8388607, 256, 0, 0, 0, 0, 0},
        '{    1234,      -77, 257, 1,     1234,      -77, 32768, 1},
        '{       0,       -1, 511, 1,        0,       -1, 32768, 1},
        '{     100,      100,   0, 0, 0, 0, 0, 0},
        '{       1,        0,   1, 0, 0, 0, 0, 0},
        '{-8388608,        0,   2, 0, 0, 0, 0, 0},
        '{       0,  8388607, 255, 0, 0, 0, 0, 0},
        '{ 5592405, -5592406, 170, 0, 0, 0, 0, 0},
        '{    5000,    -5000,  85, 0, 0, 0, 0, 0}
    };

    reg_set_t settings [6] = '{
        '{ 256,     66,     0,        2,  8388608,        2, 0},
        '{1280,  65536, 64881,        1, 16777216,        0, 1},
        '{ 300, 131071, 32768,        0,        1,        1, 1},
        '{ 512,   1000, 50000,        3,  5592405,        3, 0},
        '{ 256,     66,     0, 16777215,        1, 16777215, 0},
        '{1024,  20000, 10000,        0, 16777216,        8, 1}
    };

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void model_reset();
        alpha_q    = 11'd256;
        floor_sq_q = 17'd66;
        smooth_q   = 16'd0;
        lframes_q  = 24'd1;
        lweight_q  = 25'd16777216;
        window_q   = 24'd8;
        clamp_q    = 1'b0;
        for (int k = 0; k < NUM_BINS; k++)
        begin
            noise_est[k] = '0;
            min_track[k] = PW_ONES;
            gain_hist[k] = GAIN_ONE;
        end
        learn_left   = lframes_q;
        window_count = '0;
        frame_mode_q = MODE_TRACK;
    endfunction

    function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_OVERSUB: alpha_q = val[10:0];
            REG_FLOOR:   floor_sq_q = val[16:0];
            REG_SMOOTH:  smooth_q = val[15:0];
            REG_LFRAMES:
            begin
                lframes_q  = val[23:0];
                learn_left = val[23:0];
            end
            REG_LWEIGHT: lweight_q = val[24:0];
            REG_WINDOW:  window_q = val[23:0];
            REG_CLAMP:   clamp_q = val[0];
            default: ;
        endcase
    endfunction

    // integer square root, rounded to nearest
    function automatic int unsigned round_sqrt(int unsigned v);
        int unsigned root = 0;
        int unsigned rest = v;
        int unsigned bitv = 32'd1 << 30;
        while (bitv > rest)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rest >= root + bitv)
            begin
                rest -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        if (rest > root)
            root++;
        return root;
    endfunction

    function automatic logic [23:0] apply_gain(longint signed v, int unsigned g);
        longint signed t;
        t = v * longint'(g) + 64'sd16384;
        t = t >>> 15;
        return t[23:0];
    endfunction

    function automatic bin_res_t predict_bin(logic signed [23:0] re, logic signed [23:0] im,
                                             logic [IDX_W-1:0] idx);
        bin_res_t        res;
        longint signed   r;
        longint signed   i;
        longint unsigned p, n, m, add, lim, den, num, ratio, g2, s;
        int unsigned     g;
        r = re;
        i = im;
        if (idx == 0)
        begin
            if (learn_left != 0)
            begin
                learn_left--;
                frame_mode_q = (learn_left == 0) ? MODE_LAST : MODE_LEARN;
            end
            else
            begin
                if (window_count != CNT_MAX)
                    window_count++;
                if (window_count >= window_q)
                begin
                    frame_mode_q = MODE_ADOPT;
                    window_count = '0;
                end
                else
                    frame_mode_q = MODE_TRACK;
            end
        end
        res.idx      = idx;
        res.learning = (frame_mode_q == MODE_LEARN || frame_mode_q == MODE_LAST);
        if (idx >= NUM_BINS)
        begin
            res.re   = re;
            res.im   = im;
            res.gain = GAIN_ONE;
            return res;
        end
        p = longint'(r * r + i * i);
        if (p > ALL_ONES - 1)
            p = ALL_ONES - 1;
        n = noise_est[idx];
        if (res.learning)
        begin
            add = (p >> 24) * lweight_q + (((p & 64'hFF_FFFF) * lweight_q) >> 24);
            n += add;
            if (n > ALL_ONES)
                n = ALL_ONES;
            if (frame_mode_q == MODE_LAST && n < 1)
                n = 1;
        end
        else if (frame_mode_q == MODE_ADOPT)
        begin
            m = min_track[idx];
            if (m == ALL_ONES)
                m = n;
            if (m < 1)
                m = 1;
            n = (64'd45875 * n + 64'd19661 * m + 64'd32768) >> 16;
            if (clamp_q)
            begin
                lim = p + (p >> 1);
                if (n > lim)
                    n = lim;
                if (n < 1)
                    n = 1;
            end
            min_track[idx] = p[47:0];
        end
        else if (p < min_track[idx])
            min_track[idx] = p[47:0];
        noise_est[idx] = n[47:0];

        den = (p < 1) ? 1 : p;
        num = alpha_q * n;
        if (num >= den * 256)
            g2 = 0;
        else
        begin
            ratio = (num * 256) / den;
            g2 = (ratio >= 65536) ? 0 : 65536 - ratio;
        end
        if (g2 < floor_sq_q)
            g2 = floor_sq_q;
        if (g2 > 65536)
            g2 = 65536;
        g = round_sqrt(int'(g2 << 14));
        if (g > 32768)
            g = 32768;
        s = (smooth_q * longint'(gain_hist[idx]) + (64'd65536 - smooth_q) * g + 64'd32768) >> 16;
        if (s > 32768)
            s = 32768;
        gain_hist[idx] = s[15:0];
        res.re   = apply_gain(r, s);
        res.im   = apply_gain(i, s);
        res.gain = s[15:0];
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic put_bin(logic signed [23:0] re, logic signed [23:0] im,
                           logic [IDX_W-1:0] idx);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            spectrum.valid <= 1'b0;
            @(posedge clk);
        end
        spectrum.valid     <= 1'b1;
        spectrum.bin_re    <= re;
        spectrum.bin_im    <= im;
        spectrum.bin_index <= idx;
        do
            @(posedge clk);
        while (!spectrum.ready);
        expected_q.push_back(predict_bin(re, im, idx));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        model_write(idx, val);
    endtask

    task automatic drain();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [23:0] draw_sample(int level);
        logic signed [23:0] v;
        v = 24'($urandom);
        case ($urandom_range(0, 9))
            0: ;
            1: v = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            2, 3: v = v >>> $urandom_range(0, 8);
            default: v = v >>> level;
        endcase
        return v;
    endfunction

    // result side: check each accepted word, then pick ready for the next edge
    always @(posedge clk)
    begin
        bin_res_t want;
        if (rst_n && cleaned.valid && cleaned.ready)
        begin
            if (expected_q.size() == 0)
                report("unexpected word, index", cleaned.out_index, -1);
            else
            begin
                want = expected_q.pop_front();
                if (cleaned.out_re !== want.re)
                    report("out_re", cleaned.out_re, want.re);
                if (cleaned.out_im !== want.im)
                    report("out_im", cleaned.out_im, want.im);
                if (cleaned.gain !== want.gain)
                    report("gain", cleaned.gain, want.gain);
                if (cleaned.out_index !== want.idx)
                    report("out_index", cleaned.out_index, want.idx);
                if (cleaned.learning !== want.learning)
                    report("learning", cleaned.learning, want.learning);
            end
        end
        if (pressure_req != pressure_seen)
        begin
            pressure_seen  <= pressure_req;
            hold_left      <= HOLD_CYCLES;
            cleaned.ready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            cleaned.ready <= 1'b0;
        end
        else
            cleaned.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int level;
        int gap;
        int cur;
        rst_n              <= 1'b0;
        cfg_write          <= 1'b0;
        cfg_index          <= REG_OVERSUB;
        cfg_data           <= '0;
        spectrum.valid     <= 1'b0;
        spectrum.bin_re    <= '0;
        spectrum.bin_im    <= '0;
        spectrum.bin_index <= '0;
        model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed bins under reset settings
        foreach (probes[k])
        begin
            put_bin(24'(probes[k].re), 24'(probes[k].im), 9'(probes[k].idx));
            if (probes[k].fixed)
            begin
                expected_q[expected_q.size() - 1].re       = 24'(probes[k].w_re);
                expected_q[expected_q.size() - 1].im       = 24'(probes[k].w_im);
                expected_q[expected_q.size() - 1].gain     = 16'(probes[k].w_gain);
                expected_q[expected_q.size() - 1].learning = probes[k].w_learn;
            end
        end

        foreach (settings[ph])
        begin
            spectrum.valid <= 1'b0;
            drain();
            for (int r = 0; r < 7; r++)
                write_reg(CFG_IDX_W'(r), CFG_W'(settings[ph][r]));
            cfg_write <= 1'b0;
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            // long receiver hold-off while words keep coming, fills the pipeline
            if (ph == 0)
                pressure_req++;
            level = $urandom_range(6, 18);
            sent  = 0;
            while (sent < PHASE_WORDS)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    put_bin(24'($urandom), 24'($urandom), 9'($urandom));
                    sent++;
                end
                else
                begin
                    // one frame: bin 0, then rising bin numbers with random spacing
                    gap = ($urandom_range(0, 4) == 0) ? 3 : 40;
                    put_bin(draw_sample(level), draw_sample(level), '0);
                    sent++;
                    cur = $urandom_range(1, gap);
                    while (cur < NUM_BINS && sent < PHASE_WORDS)
                    begin
                        put_bin(draw_sample(level), draw_sample(level), 9'(cur));
                        sent++;
                        cur += $urandom_range(1, gap);
                    end
                end
            end
        end

        spectrum.valid <= 1'b0;
        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: filelist.f
sv/ssg_pkg.sv
sv/ssg_bin_if.sv
sv/ssg_res_if.sv
sv/ssg_ram.sv
sv/spectral_subtraction_gain_unit.sv
dv/tb.sv
